[hw/rtl/lsrm_pkg.sv]
// Shared codes, defaults and control/status types of the layer slot residency manager.
package lsrm_pkg;

    localparam int MAX_LAYERS_DEF = 128;
    localparam int MAX_SLOTS_DEF  = 16;
    localparam int STAMP_BITS_DEF = 32;
    localparam int MAX_AHEAD      = 63;

    // Operation codes.
    localparam logic [2:0] OP_REQUEST   = 3'd0;
    localparam logic [2:0] OP_LOAD_DONE = 3'd1;
    localparam logic [2:0] OP_RELEASE   = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_PIN       = 3'd4;
    localparam logic [2:0] OP_BEGIN     = 3'd5;
    localparam logic [2:0] OP_ADVANCE   = 3'd6;
    localparam logic [2:0] OP_UNUSED    = 3'd7;

    // Result kinds.
    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_HIT     = 3'd1;
    localparam logic [2:0] KIND_LOADING = 3'd2;
    localparam logic [2:0] KIND_ISSUE   = 3'd3;
    localparam logic [2:0] KIND_NOSLOT  = 3'd4;
    localparam logic [2:0] KIND_ACK     = 3'd5;
    localparam logic [2:0] KIND_QUERY   = 3'd6;

    // Residency states.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_LOADING  = 2'd1;
    localparam logic [1:0] ST_RESIDENT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAYER_COUNT    = 2'd0;
    localparam logic [1:0] CFG_SLOT_COUNT     = 2'd1;
    localparam logic [1:0] CFG_PREFETCH_AHEAD = 2'd2;

    // Table write selects.
    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_SINGLE  = 3'd1;
    localparam logic [2:0] WR_GRANT   = 3'd2;
    localparam logic [2:0] WR_VICTIM  = 3'd3;
    localparam logic [2:0] WR_RELEASE = 3'd4;

    // Result selects.
    localparam logic [2:0] EM_NONE    = 3'd0;
    localparam logic [2:0] EM_INVALID = 3'd1;
    localparam logic [2:0] EM_SINGLE  = 3'd2;
    localparam logic [2:0] EM_REQ     = 3'd3;
    localparam logic [2:0] EM_ISSUE   = 3'd4;
    localparam logic [2:0] EM_NOSLOT  = 3'd5;

    typedef struct packed {
        logic       load_item;
        logic       init_single;
        logic       init_begin;
        logic       init_adv;
        logic       step_next;
        logic       tgt_prev;
        logic       tgt_rd;
        logic       scan_clr;
        logic       scan_rd;
        logic       free_grant;
        logic       victim_grant;
        logic [2:0] wr;
        logic [2:0] em;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       layer_ok;
        logic       adv_match;
        logic [1:0] tgt_res;
        logic       free_found;
        logic       scan_end;
        logic       found;
        logic       more;
        logic       rel_needed;
        logic       out_free;
    } sts_t;

endpackage

[hw/rtl/lsrm_ctrl.sv]
// Sequencing state machine of the layer slot residency manager.
module lsrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  lsrm_pkg::sts_t    sts,
    output lsrm_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_INV    = 4'd2;
    localparam logic [3:0] S_RQ_RD  = 4'd3;
    localparam logic [3:0] S_RQ_CHK = 4'd4;
    localparam logic [3:0] S_SC_RUN = 4'd5;
    localparam logic [3:0] S_RQ_EV  = 4'd6;
    localparam logic [3:0] S_RQ_GNT = 4'd7;
    localparam logic [3:0] S_RQ_NXT = 4'd8;
    localparam logic [3:0] S_REL_RD = 4'd9;
    localparam logic [3:0] S_REL_DO = 4'd10;
    localparam logic [3:0] S_SG_RD  = 4'd11;
    localparam logic [3:0] S_SG_DO  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.wr     = lsrm_pkg::WR_NONE;
        cmd.em     = lsrm_pkg::EM_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.op == lsrm_pkg::OP_UNUSED ||
                    (sts.op != lsrm_pkg::OP_BEGIN && !sts.layer_ok))
                begin
                    state_next = S_INV;
                end
                else if (sts.op == lsrm_pkg::OP_REQUEST)
                begin
                    cmd.init_single = 1'b1;
                    state_next      = S_RQ_RD;
                end
                else if (sts.op == lsrm_pkg::OP_BEGIN)
                begin
                    cmd.init_begin = 1'b1;
                    state_next     = S_RQ_RD;
                end
                else if (sts.op == lsrm_pkg::OP_ADVANCE && !sts.adv_match)
                begin
                    cmd.init_adv = 1'b1;
                    state_next   = S_RQ_RD;
                end
                else
                begin
                    cmd.init_single = 1'b1;
                    state_next      = S_SG_RD;
                end
            end
            S_INV:
            begin
                if (sts.out_free)
                begin
                    cmd.em     = lsrm_pkg::EM_INVALID;
                    state_next = S_IDLE;
                end
            end
            S_RQ_RD:
            begin
                cmd.tgt_rd = 1'b1;
                state_next = S_RQ_CHK;
            end
            S_RQ_CHK:
            begin
                if (sts.tgt_res == lsrm_pkg::ST_RESIDENT || sts.tgt_res == lsrm_pkg::ST_LOADING)
                begin
                    if (sts.out_free)
                    begin
                        cmd.em     = lsrm_pkg::EM_REQ;
                        state_next = S_RQ_NXT;
                    end
                end
                else if (sts.free_found)
                begin
                    cmd.free_grant = 1'b1;
                    state_next     = S_RQ_GNT;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SC_RUN;
                end
            end
            S_SC_RUN:
            begin
                if (!sts.scan_end)
                    cmd.scan_rd = 1'b1;
                else
                    state_next = S_RQ_EV;
            end
            S_RQ_EV:
            begin
                if (sts.found)
                begin
                    cmd.wr           = lsrm_pkg::WR_VICTIM;
                    cmd.victim_grant = 1'b1;
                    state_next       = S_RQ_GNT;
                end
                else if (sts.out_free)
                begin
                    cmd.em     = lsrm_pkg::EM_NOSLOT;
                    state_next = S_RQ_NXT;
                end
            end
            S_RQ_GNT:
            begin
                if (sts.out_free)
                begin
                    cmd.wr     = lsrm_pkg::WR_GRANT;
                    cmd.em     = lsrm_pkg::EM_ISSUE;
                    state_next = S_RQ_NXT;
                end
            end
            S_RQ_NXT:
            begin
                if (sts.more)
                begin
                    cmd.step_next = 1'b1;
                    state_next    = S_RQ_RD;
                end
                else if (sts.rel_needed)
                begin
                    cmd.tgt_prev = 1'b1;
                    state_next   = S_REL_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REL_RD:
            begin
                cmd.tgt_rd = 1'b1;
                state_next = S_REL_DO;
            end
            S_REL_DO:
            begin
                cmd.wr     = lsrm_pkg::WR_RELEASE;
                state_next = S_IDLE;
            end
            S_SG_RD:
            begin
                cmd.tgt_rd = 1'b1;
                state_next = S_SG_DO;
            end
            S_SG_DO:
            begin
                if (sts.out_free)
                begin
                    cmd.wr     = lsrm_pkg::WR_SINGLE;
                    cmd.em     = lsrm_pkg::EM_SINGLE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/lsrm_datapath.sv]
// Layer table, slot owner bits, victim scan, stamp counter and result register.
module lsrm_datapath #(
    parameter int MAX_LAYERS = lsrm_pkg::MAX_LAYERS_DEF,
    parameter int MAX_SLOTS  = lsrm_pkg::MAX_SLOTS_DEF,
    parameter int STAMP_BITS = lsrm_pkg::STAMP_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic [2:0]     in_op,
    input  logic [6:0]     in_layer,
    input  logic           in_load_ok,
    input  logic           m_tready,
    input  lsrm_pkg::cmd_t cmd,
    output lsrm_pkg::sts_t sts,
    output logic           out_valid,
    output logic [2:0]     out_kind,
    output logic [6:0]     out_layer,
    output logic [3:0]     out_slot,
    output logic           out_slot_valid,
    output logic           out_evicted,
    output logic [6:0]     out_evicted_layer,
    output logic           out_resident,
    output logic           out_last
);

    localparam int AW = $clog2(MAX_LAYERS);
    localparam int NW = $clog2(MAX_LAYERS + 1);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int KW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (NW > 8) ? NW : 8;

    typedef struct packed {
        logic [1:0]            res;
        logic                  held;
        logic [SW-1:0]         slot;
        logic                  rel;
        logic [STAMP_BITS-1:0] stamp;
    } ent_t;

    localparam ent_t RST_ENT = '{lsrm_pkg::ST_NONE, 1'b0, '0, 1'b1, '0};

    function automatic logic [6:0] lay7(input logic [AW-1:0] x);
        logic [AW+6:0] w;
        w = (AW+7)'(x);
        return w[6:0];
    endfunction

    function automatic logic [AW-1:0] lay_aw(input logic [6:0] x);
        logic [AW+6:0] w;
        w = (AW+7)'(x);
        return w[AW-1:0];
    endfunction

    function automatic logic [3:0] slot4(input logic [SW-1:0] x);
        logic [SW+3:0] w;
        w = (SW+4)'(x);
        return w[3:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] y;
        y = NW'(x) + NW'(1);
        return (y == n) ? '0 : y[AW-1:0];
    endfunction

    // Configuration and effective limits.
    logic [7:0]    layer_count_reg;
    logic [4:0]    slot_count_reg;
    logic [5:0]    prefetch_ahead_reg;
    logic [CW-1:0] n_x;
    logic [CW-1:0] k_x;
    logic [CW-1:0] a_x;
    logic [NW-1:0] n_eff;
    logic [KW-1:0] k_eff;
    logic [5:0]    ahead;

    // Item and sequencing registers.
    logic [2:0]            op_reg;
    logic [6:0]            in_layer_reg;
    logic                  ok_reg;
    logic [AW-1:0]         tgt_reg;
    logic [5:0]            cnt_reg;
    logic                  multi_reg;
    logic                  compute_valid_reg;
    logic [6:0]            compute_layer_reg;
    logic                  prev_valid_reg;
    logic [6:0]            prev_layer_reg;
    logic [SW-1:0]         gslot_reg;
    logic                  evict_reg;
    logic [AW-1:0]         victim_reg;
    logic [STAMP_BITS-1:0] best_reg;
    logic [SW-1:0]         best_slot_reg;
    logic                  found_reg;
    logic [NW-1:0]         scan_idx_reg;
    logic [AW-1:0]         scan_eidx_reg;
    logic                  scan_pend_reg;
    logic [MAX_SLOTS-1:0]  owner_valid_reg;
    logic [STAMP_BITS-1:0] event_clk_reg;

    // Layer table.
    ent_t                  mem [MAX_LAYERS];
    logic [MAX_LAYERS-1:0] vld_reg;
    ent_t                  tgt_word_reg;
    ent_t                  scan_word_reg;
    logic                  tgt_vld_reg;
    logic                  scan_vld_reg;
    ent_t                  tgt_ent;
    ent_t                  scan_ent;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    ent_t                  wr_word;
    logic                  take;
    logic                  free_en;
    logic                  claim_en;
    logic [SW-1:0]         free_idx;
    logic                  free_found;
    logic                  scan_hit;
    logic                  out_free;
    logic                  emit;

    logic [2:0] e_kind;
    logic [6:0] e_layer;
    logic [3:0] e_slot;
    logic       e_sv;
    logic       e_ev;
    logic [6:0] e_evl;
    logic       e_res;
    logic       e_last;

    logic out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [6:0] out_layer_reg;
    logic [3:0] out_slot_reg;
    logic       out_sv_reg;
    logic       out_ev_reg;
    logic [6:0] out_evl_reg;
    logic       out_res_reg;
    logic       out_last_reg;

    always_comb
    begin
        n_x = CW'(layer_count_reg);
        if (n_x == '0)
            n_x = CW'(1);
        else if (n_x > CW'(MAX_LAYERS))
            n_x = CW'(MAX_LAYERS);
        k_x = CW'(slot_count_reg);
        if (k_x > n_x)
            k_x = n_x;
        if (k_x > CW'(MAX_SLOTS))
            k_x = CW'(MAX_SLOTS);
        if (k_x == '0)
            k_x = CW'(1);
        a_x = CW'(prefetch_ahead_reg);
        if (a_x > n_x - CW'(1))
            a_x = n_x - CW'(1);
        if (a_x > CW'(lsrm_pkg::MAX_AHEAD))
            a_x = CW'(lsrm_pkg::MAX_AHEAD);
        if (a_x == '0)
            a_x = CW'(1);
        n_eff = NW'(n_x);
        k_eff = KW'(k_x);
        ahead = a_x[5:0];
    end

    assign tgt_ent  = tgt_vld_reg  ? tgt_word_reg  : RST_ENT;
    assign scan_ent = scan_vld_reg ? scan_word_reg : RST_ENT;

    // Lowest free slot among those in use.
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (KW'(i) < k_eff && !owner_valid_reg[i])
            begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign scan_hit = scan_pend_reg && scan_ent.held && (KW'(scan_ent.slot) < k_eff) &&
                      scan_ent.rel && (scan_ent.res == lsrm_pkg::ST_RESIDENT) &&
                      (!found_reg || scan_ent.stamp < best_reg);

    // Table write.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = tgt_reg;
        wr_word  = tgt_ent;
        take     = 1'b0;
        free_en  = 1'b0;
        claim_en = 1'b0;
        case (cmd.wr)
            lsrm_pkg::WR_SINGLE:
            begin
                case (op_reg)
                    lsrm_pkg::OP_LOAD_DONE:
                    begin
                        if (tgt_ent.res == lsrm_pkg::ST_LOADING)
                        begin
                            wr_en = 1'b1;
                            if (ok_reg)
                            begin
                                wr_word.res   = lsrm_pkg::ST_RESIDENT;
                                wr_word.stamp = event_clk_reg;
                                take          = 1'b1;
                            end
                            else
                            begin
                                free_en      = tgt_ent.held;
                                wr_word.res  = lsrm_pkg::ST_NONE;
                                wr_word.held = 1'b0;
                                wr_word.slot = '0;
                            end
                        end
                    end
                    lsrm_pkg::OP_RELEASE:
                    begin
                        wr_en         = 1'b1;
                        wr_word.rel   = 1'b1;
                        wr_word.stamp = event_clk_reg;
                        take          = 1'b1;
                    end
                    lsrm_pkg::OP_PIN:
                    begin
                        wr_en        = 1'b1;
                        free_en      = tgt_ent.held;
                        wr_word.res  = lsrm_pkg::ST_RESIDENT;
                        wr_word.held = 1'b0;
                        wr_word.slot = '0;
                        wr_word.rel  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lsrm_pkg::WR_GRANT:
            begin
                wr_en        = 1'b1;
                claim_en     = 1'b1;
                wr_word.res  = lsrm_pkg::ST_LOADING;
                wr_word.held = 1'b1;
                wr_word.slot = gslot_reg;
                wr_word.rel  = 1'b0;
            end
            lsrm_pkg::WR_VICTIM:
            begin
                wr_en   = 1'b1;
                wr_addr = victim_reg;
                wr_word = '{lsrm_pkg::ST_NONE, 1'b0, '0, 1'b1, best_reg};
            end
            lsrm_pkg::WR_RELEASE:
            begin
                wr_en         = 1'b1;
                wr_word.rel   = 1'b1;
                wr_word.stamp = event_clk_reg;
                take          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
        if (cmd.tgt_rd)
        begin
            tgt_word_reg <= mem[tgt_reg];
            tgt_vld_reg  <= vld_reg[tgt_reg];
        end
        if (cmd.scan_rd)
        begin
            scan_word_reg <= mem[scan_idx_reg[AW-1:0]];
            scan_vld_reg  <= vld_reg[scan_idx_reg[AW-1:0]];
            scan_eidx_reg <= scan_idx_reg[AW-1:0];
        end
    end

    // Result selection.
    always_comb
    begin
        e_kind  = lsrm_pkg::KIND_INVALID;
        e_layer = lay7(tgt_reg);
        e_slot  = '0;
        e_sv    = 1'b0;
        e_ev    = 1'b0;
        e_evl   = '0;
        e_res   = 1'b0;
        e_last  = !(multi_reg && cnt_reg < ahead);
        case (cmd.em)
            lsrm_pkg::EM_INVALID:
            begin
                e_layer = in_layer_reg;
                e_last  = 1'b1;
            end
            lsrm_pkg::EM_SINGLE:
            begin
                e_last = 1'b1;
                case (op_reg)
                    lsrm_pkg::OP_LOAD_DONE:
                    begin
                        if (tgt_ent.res == lsrm_pkg::ST_LOADING)
                        begin
                            e_kind = lsrm_pkg::KIND_ACK;
                            if (ok_reg)
                            begin
                                e_sv   = tgt_ent.held;
                                e_slot = tgt_ent.held ? slot4(tgt_ent.slot) : '0;
                                e_res  = 1'b1;
                            end
                        end
                    end
                    lsrm_pkg::OP_RELEASE, lsrm_pkg::OP_QUERY:
                    begin
                        e_kind = (op_reg == lsrm_pkg::OP_QUERY) ? lsrm_pkg::KIND_QUERY
                                                                : lsrm_pkg::KIND_ACK;
                        e_sv   = tgt_ent.held;
                        e_slot = tgt_ent.held ? slot4(tgt_ent.slot) : '0;
                        e_res  = (tgt_ent.res == lsrm_pkg::ST_RESIDENT);
                    end
                    lsrm_pkg::OP_PIN:
                    begin
                        e_kind = lsrm_pkg::KIND_ACK;
                        e_res  = 1'b1;
                    end
                    lsrm_pkg::OP_ADVANCE:
                    begin
                        e_kind = lsrm_pkg::KIND_ACK;
                        e_res  = (tgt_ent.res == lsrm_pkg::ST_RESIDENT);
                    end
                    default:
                    begin
                    end
                endcase
            end
            lsrm_pkg::EM_REQ:
            begin
                e_res  = (tgt_ent.res == lsrm_pkg::ST_RESIDENT);
                e_kind = e_res ? lsrm_pkg::KIND_HIT : lsrm_pkg::KIND_LOADING;
                e_sv   = tgt_ent.held;
                e_slot = tgt_ent.held ? slot4(tgt_ent.slot) : '0;
            end
            lsrm_pkg::EM_ISSUE:
            begin
                e_kind = lsrm_pkg::KIND_ISSUE;
                e_sv   = 1'b1;
                e_slot = slot4(gslot_reg);
                e_ev   = evict_reg;
                e_evl  = evict_reg ? lay7(victim_reg) : '0;
            end
            lsrm_pkg::EM_NOSLOT:
            begin
                e_kind = lsrm_pkg::KIND_NOSLOT;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (cmd.em != lsrm_pkg::EM_NONE);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg  <= e_kind;
            out_layer_reg <= e_layer;
            out_slot_reg  <= e_slot;
            out_sv_reg    <= e_sv;
            out_ev_reg    <= e_ev;
            out_evl_reg   <= e_evl;
            out_res_reg   <= e_res;
            out_last_reg  <= e_last;
        end
        if (cmd.load_item)
        begin
            op_reg       <= in_op;
            in_layer_reg <= in_layer;
            ok_reg       <= in_load_ok;
        end
        if (cmd.free_grant)
        begin
            gslot_reg <= free_idx;
            evict_reg <= 1'b0;
        end
        else if (cmd.victim_grant)
        begin
            gslot_reg <= best_slot_reg;
            evict_reg <= 1'b1;
        end
        if (scan_hit)
        begin
            best_reg      <= scan_ent.stamp;
            best_slot_reg <= scan_ent.slot;
            victim_reg    <= scan_eidx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg    <= 8'd128;
            slot_count_reg     <= 5'd16;
            prefetch_ahead_reg <= 6'd1;
            out_valid_reg      <= 1'b0;
            tgt_reg            <= '0;
            cnt_reg            <= '0;
            multi_reg          <= 1'b0;
            compute_valid_reg  <= 1'b0;
            compute_layer_reg  <= '0;
            prev_valid_reg     <= 1'b0;
            prev_layer_reg     <= '0;
            found_reg          <= 1'b0;
            scan_idx_reg       <= '0;
            scan_pend_reg      <= 1'b0;
            owner_valid_reg    <= '0;
            vld_reg            <= '0;
            event_clk_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lsrm_pkg::CFG_LAYER_COUNT:    layer_count_reg    <= cfg_data;
                    lsrm_pkg::CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[4:0];
                    lsrm_pkg::CFG_PREFETCH_AHEAD: prefetch_ahead_reg <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cmd.init_single)
            begin
                tgt_reg   <= lay_aw(in_layer_reg);
                multi_reg <= 1'b0;
            end
            else if (cmd.init_begin)
            begin
                tgt_reg           <= '0;
                cnt_reg           <= '0;
                multi_reg         <= 1'b1;
                compute_valid_reg <= 1'b0;
                compute_layer_reg <= '0;
                prev_valid_reg    <= 1'b0;
            end
            else if (cmd.init_adv)
            begin
                tgt_reg           <= wrap_inc(lay_aw(in_layer_reg), n_eff);
                cnt_reg           <= 6'd1;
                multi_reg         <= 1'b1;
                prev_valid_reg    <= compute_valid_reg;
                prev_layer_reg    <= compute_layer_reg;
                compute_valid_reg <= 1'b1;
                compute_layer_reg <= in_layer_reg;
            end
            else if (cmd.step_next)
            begin
                tgt_reg <= wrap_inc(tgt_reg, n_eff);
                cnt_reg <= cnt_reg + 6'd1;
            end
            else if (cmd.tgt_prev)
            begin
                tgt_reg <= lay_aw(prev_layer_reg);
            end

            if (cmd.scan_clr)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                    scan_idx_reg <= scan_idx_reg + NW'(1);
                if (scan_hit)
                    found_reg <= 1'b1;
            end
            scan_pend_reg <= cmd.scan_rd;

            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (free_en)
                owner_valid_reg[tgt_ent.slot] <= 1'b0;
            if (claim_en)
                owner_valid_reg[gslot_reg] <= 1'b1;
            if (take && event_clk_reg != '1)
                event_clk_reg <= event_clk_reg + STAMP_BITS'(1);
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.layer_ok   = (CW'(in_layer_reg) < CW'(n_eff));
        sts.adv_match  = compute_valid_reg && (compute_layer_reg == in_layer_reg);
        sts.tgt_res    = tgt_ent.res;
        sts.free_found = free_found;
        sts.scan_end   = (scan_idx_reg == n_eff);
        sts.found      = found_reg;
        sts.more       = multi_reg && (cnt_reg < ahead);
        sts.rel_needed = (op_reg == lsrm_pkg::OP_ADVANCE) && prev_valid_reg &&
                         (CW'(prev_layer_reg) < CW'(n_eff));
        sts.out_free   = out_free;
    end

    assign out_valid         = out_valid_reg;
    assign out_kind          = out_kind_reg;
    assign out_layer         = out_layer_reg;
    assign out_slot          = out_slot_reg;
    assign out_slot_valid    = out_sv_reg;
    assign out_evicted       = out_ev_reg;
    assign out_evicted_layer = out_evl_reg;
    assign out_resident      = out_res_reg;
    assign out_last          = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result loaded while the output register is occupied");

    a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 event_clk_reg >= $past(event_clk_reg))
        else $error("event clock moved backwards");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> scan_idx_reg < n_eff)
        else $error("victim scan past the layer count");

    a_grant_claim: assert property (@(posedge clk) disable iff (!rst_n)
        claim_en |=> owner_valid_reg[$past(gslot_reg)])
        else $error("granted slot not marked owned");

endmodule

[hw/rtl/layer_slot_residency_manager_core.sv]
// Top level of the layer slot residency manager.
//
// Operations arrive on the s_axis channel and results leave on m_axis; each
// transaction on the input yields one or more results, the final one marked by
// tlast. Configuration registers are written through cfg_we/cfg_index/cfg_data
// while no transaction is in flight; this binds the user, the block does not enforce it.
// Items are handled one at a time. A query, release, pin or load_done reads its
// layer's table entry, then loads its result and updates the entry as needed.
// A request that hits is answered from its entry, one that misses takes a free
// slot if there is one, and one that finds no free slot scans the layer table
// one entry per cycle through the table's read port, evicting a layer if it
// finds one. Begin repeats the request sequence for each prefetched layer;
// advance issues one request fewer and then releases the previous layer.
// Reset empties every slot and sets every layer not resident, released, with
// stamp zero; per-entry valid bits make this immediate with no clearing pass.
// A stalled receiver holds the result register; the block then waits before
// loading the next result, but accepts a new input once the current one is done.
module layer_slot_residency_manager_core #(
    parameter int MAX_LAYERS = lsrm_pkg::MAX_LAYERS_DEF,
    parameter int MAX_SLOTS  = lsrm_pkg::MAX_SLOTS_DEF,
    parameter int STAMP_BITS = lsrm_pkg::STAMP_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op[2:0], layer[9:3], load_ok[10], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_layer[6:0], slot[10:7], slot_valid[11],
                                        // evicted[12], evicted_layer[19:13], resident[20]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast
);

    lsrm_pkg::cmd_t cmd;
    lsrm_pkg::sts_t sts;
    logic [6:0]     out_layer;
    logic [3:0]     out_slot;
    logic           out_slot_valid;
    logic           out_evicted;
    logic [6:0]     out_evicted_layer;
    logic           out_resident;

    lsrm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lsrm_datapath #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_SLOTS  (MAX_SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_op             (s_axis_tdata[2:0]),
        .in_layer          (s_axis_tdata[9:3]),
        .in_load_ok        (s_axis_tdata[10]),
        .m_tready          (m_axis_tready),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (m_axis_tvalid),
        .out_kind          (m_axis_tuser),
        .out_layer         (out_layer),
        .out_slot          (out_slot),
        .out_slot_valid    (out_slot_valid),
        .out_evicted       (out_evicted),
        .out_evicted_layer (out_evicted_layer),
        .out_resident      (out_resident),
        .out_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_resident, out_evicted_layer, out_evicted,
                           out_slot_valid, out_slot, out_layer};

endmodule
